/* rtl/hsc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hsc_pkg
// Shared types and constants (including the FNV hash constants) for the hashed slot cache.
// ----------------------------------------------------------------------------
package hsc_pkg;

  localparam int TABLE_SIZE_DEF = 32;
  localparam logic [7:0] MIN_AGE_RESET = 8'd2;
  localparam logic [31:0] FNV_OFFSET = 32'h811C9DC5;
  localparam logic [31:0] FNV_PRIME = 32'h01000193;

  localparam logic [2:0] KIND_HIT = 3'd0;
  localparam logic [2:0] KIND_INSERT = 3'd1;
  localparam logic [2:0] KIND_FAIL = 3'd2;
  localparam logic [2:0] KIND_FREED = 3'd3;
  localparam logic [2:0] KIND_DONE = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HASH,
    ST_PROBE_RD,
    ST_PROBE_CHK,
    ST_HIT_RD,
    ST_HIT_UPD,
    ST_INSERT,
    ST_EV_RD,
    ST_EV_CHK,
    ST_DONE
  } state_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load;        // capture input item
    logic hash_step;   // one FNV byte
    logic probe_start; // set probe index from hash
    logic probe_rd;    // issue slot read at probe index
    logic probe_next;  // advance probe index
    logic hit_rd;      // read links of probe slot
    logic hit_upd;     // unlink and append probe slot / stamp it
    logic insert;      // fill probe slot and append
    logic ev_rd;       // read oldest slot
    logic ev_free;     // free oldest slot, emit handle
    logic emit_fail;
    logic emit_done;
    logic emit_hit;
  } hsc_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic is_frame;
    logic key_zero;
    logic hash_done;
    logic key_match;
    logic slot_empty;
    logic wrapped;
    logic oldest_none;
    logic age_ok;
    logic guard_done;
  } hsc_stat_t;

endpackage

`default_nettype wire

/* rtl/hsc_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hsc_ctrl
// Sequencer for request probing and frame eviction.
// ----------------------------------------------------------------------------
module hsc_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              start,
  output logic             busy,
  input  hsc_pkg::hsc_stat_t stat,
  output hsc_pkg::hsc_cmd_t  cmd
);
  import hsc_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (start) state_next = ST_HASH;
      ST_HASH: begin
        if (stat.is_frame) state_next = ST_EV_RD;
        else if (stat.key_zero) state_next = ST_DONE;
        else if (stat.hash_done) state_next = ST_PROBE_RD;
      end
      ST_PROBE_RD:  state_next = ST_PROBE_CHK;
      ST_PROBE_CHK: begin
        if (stat.key_match) state_next = ST_HIT_RD;
        else if (stat.slot_empty) state_next = ST_INSERT;
        else if (stat.wrapped) state_next = ST_DONE;
        else state_next = ST_PROBE_RD;
      end
      ST_HIT_RD:    state_next = ST_HIT_UPD;
      ST_HIT_UPD:   state_next = ST_IDLE;
      ST_INSERT:    state_next = ST_IDLE;
      ST_EV_RD:     state_next = ST_EV_CHK;
      ST_EV_CHK: begin
        if (stat.oldest_none || stat.guard_done || !stat.age_ok) state_next = ST_DONE;
        else state_next = ST_EV_RD;
      end
      ST_DONE:      state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state != ST_IDLE);
    case (state)
      ST_IDLE:      cmd.load = start;
      ST_HASH: begin
        cmd.hash_step = 1'b1;
        cmd.probe_start = stat.hash_done;
      end
      ST_PROBE_RD:  cmd.probe_rd = 1'b1;
      ST_PROBE_CHK: cmd.probe_next = !stat.key_match && !stat.slot_empty;
      ST_HIT_RD:    cmd.hit_rd = 1'b1;
      ST_HIT_UPD: begin
        cmd.hit_upd = 1'b1;
        cmd.emit_hit = 1'b1;
      end
      ST_INSERT:    cmd.insert = 1'b1;
      ST_EV_RD:     cmd.ev_rd = 1'b1;
      ST_EV_CHK:
        cmd.ev_free = !(stat.oldest_none || stat.guard_done || !stat.age_ok);
      ST_DONE: begin
        cmd.emit_fail = !stat.is_frame;
        cmd.emit_done = stat.is_frame;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/hsc_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hsc_dp
// Slot table, age list, hash unit and result register.
// ----------------------------------------------------------------------------
module hsc_dp #(
  parameter int TABLE_SIZE = hsc_pkg::TABLE_SIZE_DEF
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               cmd_in,
  input  wire  [63:0]       key,
  input  wire  [15:0]       spare_handle,
  input  wire  [31:0]       frame_number,
  input  wire               cfg_valid,
  input  wire  [7:0]        cfg_data,
  input  hsc_pkg::hsc_cmd_t cmd,
  output hsc_pkg::hsc_stat_t stat,
  output logic              result_valid,
  output logic [2:0]        kind,
  output logic [15:0]       handle,
  output logic              last
);
  import hsc_pkg::*;

  localparam int IW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int LW = $clog2(TABLE_SIZE + 1);
  localparam logic [LW-1:0] NONE = LW'(TABLE_SIZE);

  // slot contents; keys and links live in flops (handles and stamps live in RAM)
  logic [63:0]     slot_key [TABLE_SIZE];
  logic [LW-1:0]   newer [TABLE_SIZE];
  logic [LW-1:0]   older [TABLE_SIZE];
  logic [LW-1:0]   oldest, newest;
  logic [31:0]     cur_frame;
  logic [7:0]      min_age;

  logic            r_frame;
  logic [63:0]     r_key;
  logic [15:0]     r_spare;
  logic [31:0]     hash;
  logic [3:0]      hcnt;
  logic [IW-1:0]   pidx, pstart;
  logic [LW-1:0]   guard;
  logic [LW-1:0]   nw, od;

  // handle and stamp RAMs
  logic            h_we, s_we;
  logic [IW-1:0]   h_waddr, h_raddr, s_waddr, s_raddr;
  logic [15:0]     h_wdata, h_rdata;
  logic [31:0]     s_wdata, s_rdata;

  hsc_ram #(.WIDTH(16), .DEPTH(TABLE_SIZE)) u_hram (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata)
  );
  hsc_ram #(.WIDTH(32), .DEPTH(TABLE_SIZE)) u_sram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  logic [IW-1:0] old_i, new_i;
  assign old_i = oldest[IW-1:0];
  assign new_i = newest[IW-1:0];

  // read addresses: probe index normally, oldest slot during eviction
  assign h_raddr = r_frame ? old_i : pidx;
  assign s_raddr = r_frame ? old_i : pidx;

  assign h_we    = cmd.insert;
  assign h_waddr = pidx;
  assign h_wdata = r_spare;
  assign s_we    = cmd.insert || cmd.hit_upd;
  assign s_waddr = pidx;
  assign s_wdata = cur_frame;

  logic [31:0] hmul;
  assign hmul = hash * FNV_PRIME;

  logic [IW-1:0] pnext;
  assign pnext = (pidx == IW'(TABLE_SIZE - 1)) ? '0 : pidx + 1'b1;

  logic [31:0] age;
  assign age = cur_frame - s_rdata;

  assign stat.is_frame    = r_frame;
  assign stat.key_zero    = (r_key == 64'd0);
  assign stat.hash_done   = (hcnt == 4'd7);
  assign stat.key_match   = (slot_key[pidx] == r_key);
  assign stat.slot_empty  = (slot_key[pidx] == 64'd0);
  assign stat.wrapped     = (pnext == pstart);
  assign stat.oldest_none = (oldest == NONE);
  assign stat.age_ok      = (age >= {24'd0, min_age});
  assign stat.guard_done  = (guard == NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      min_age <= MIN_AGE_RESET;
    end else if (cfg_valid) begin
      min_age <= cfg_data;
    end
  end

  // item capture, hash and probe index
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_frame <= cmd_in;
      r_key   <= key;
      r_spare <= spare_handle;
      hash    <= FNV_OFFSET;
      hcnt    <= '0;
      guard   <= '0;
    end
    if (cmd.hash_step) begin
      hash <= hmul ^ {24'd0, r_key[hcnt[2:0]*8 +: 8]};
      hcnt <= hcnt + 1'b1;
    end
    if (cmd.probe_start) begin
      pidx   <= IW'((hmul ^ {24'd0, r_key[63:56]}) % TABLE_SIZE);
      pstart <= IW'((hmul ^ {24'd0, r_key[63:56]}) % TABLE_SIZE);
    end
    if (cmd.probe_next) pidx <= pnext;
    if (cmd.hit_rd) begin
      nw <= newer[pidx];
      od <= older[pidx];
    end
    if (cmd.ev_free) guard <= guard + 1'b1;
  end

  // table keys, age list and current frame register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
        slot_key[i] <= '0;
        newer[i]    <= NONE;
        older[i]    <= NONE;
      end
      oldest    <= NONE;
      newest    <= NONE;
      cur_frame <= '0;
    end else begin
      if (cmd.load && cmd_in) cur_frame <= frame_number;
      if (cmd.insert) begin
        slot_key[pidx] <= r_key;
        newer[pidx] <= NONE;
        older[pidx] <= newest;
        if (newest != NONE) newer[new_i] <= LW'(pidx);
        else oldest <= LW'(pidx);
        newest <= LW'(pidx);
      end
      if (cmd.hit_upd && !(s_rdata == cur_frame || newest == LW'(pidx))) begin
        // unlink, then append at the newest end; od is none when it was oldest
        if (nw != NONE) older[nw[IW-1:0]] <= od;
        if (od != NONE) newer[od[IW-1:0]] <= nw;
        if (oldest == LW'(pidx)) oldest <= nw;
        newer[pidx] <= NONE;
        older[pidx] <= newest;
        newer[new_i] <= LW'(pidx);
        newest <= LW'(pidx);
      end
      if (cmd.ev_free) begin
        slot_key[old_i] <= '0;
        newer[old_i] <= NONE;
        older[old_i] <= NONE;
        oldest <= newer[old_i];
        if (newer[old_i] != NONE) older[newer[old_i][IW-1:0]] <= NONE;
        else newest <= NONE;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit_hit || cmd.insert || cmd.emit_fail ||
                      cmd.emit_done || cmd.ev_free;
    end
    if (cmd.emit_hit) begin
      kind <= KIND_HIT; handle <= h_rdata; last <= 1'b1;
    end else if (cmd.insert) begin
      kind <= KIND_INSERT; handle <= r_spare; last <= 1'b1;
    end else if (cmd.ev_free) begin
      kind <= KIND_FREED; handle <= h_rdata; last <= 1'b0;
    end else if (cmd.emit_fail) begin
      kind <= KIND_FAIL; handle <= '0; last <= 1'b1;
    end else if (cmd.emit_done) begin
      kind <= KIND_DONE; handle <= '0; last <= 1'b1;
    end
  end

endmodule

`default_nettype wire

/* rtl/hsc_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hsc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hsc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [WIDTH-1:0]         wdata,
  input  wire  [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/hashed_slot_cache_with_age_eviction.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hashed_slot_cache_with_age_eviction
// Linear-probing key to handle cache with an age list and frame eviction.
// ----------------------------------------------------------------------------
// Request: hash the key bytes, then read and check each probed slot, then hit,
//   insert or fail; result strobe registered in the cycle after the final state.
// Frame: read and check the oldest slot per freed entry; one result per freed handle.
// One transaction at a time, set by the shared slot read port; busy covers it.
// Synchronous reset empties the table and sets min_age to 2.
module hashed_slot_cache_with_age_eviction #(
  parameter int TABLE_SIZE = hsc_pkg::TABLE_SIZE_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  output logic        busy,
  input  wire         cmd,
  input  wire  [63:0] key,
  input  wire  [15:0] spare_handle,
  input  wire  [31:0] frame_number,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [7:0]  cfg_data,
  output logic        result_valid,
  output logic [2:0]  kind,
  output logic [15:0] handle,
  output logic        last
);
  import hsc_pkg::*;

  hsc_cmd_t  c;
  hsc_stat_t s;

  assign cfg_ready = 1'b1;

  hsc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .stat(s), .cmd(c)
  );

  hsc_dp #(.TABLE_SIZE(TABLE_SIZE)) u_dp (
    .clk(clk), .rst(rst), .cmd_in(cmd), .key(key),
    .spare_handle(spare_handle), .frame_number(frame_number),
    .cfg_valid(cfg_valid), .cfg_data(cfg_data), .cmd(c), .stat(s),
    .result_valid(result_valid), .kind(kind), .handle(handle), .last(last)
  );

endmodule

`default_nettype wire
